>>> hdl/fmsr_pkg.sv
// Shared constants and types for the first-match substring replacement block.
// Used by fmsr_cell and first_match_substring_replace; depends on nothing.
`default_nettype none

package fmsr_pkg;

    localparam int MAX_PAT   = 32;
    localparam int MAX_REP   = 32;
    localparam int NUM_CELLS = (MAX_PAT > MAX_REP) ? MAX_PAT : MAX_REP;
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);

    typedef logic [7:0]       byte_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic  w_shift;
        logic  w_load;
        cnt_t  w_pos;
        logic  p_load;
        cnt_t  p_pos;
        logic  r_load;
        logic  r_rot;
        cnt_t  r_pos;
        cnt_t  p_len;
        cnt_t  r_len;
        byte_t data;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/fmsr_cell.sv
// One cell of the chain: a pattern byte, a window byte and a replacement byte.
// Depends on fmsr_pkg for the control struct and the counter width.
`default_nettype none

module fmsr_cell (
    input  wire logic              clk,
    input  wire fmsr_pkg::cnt_t    idx,
    input  wire fmsr_pkg::cell_ctl_t ctl,
    input  wire fmsr_pkg::byte_t   w_right,
    input  wire fmsr_pkg::byte_t   r_right,
    input  wire fmsr_pkg::byte_t   r_head,
    output fmsr_pkg::byte_t        w_byte,
    output fmsr_pkg::byte_t        r_byte,
    output logic                   hit
);

    fmsr_pkg::byte_t w_reg;
    fmsr_pkg::byte_t w_next;
    fmsr_pkg::byte_t p_reg;
    fmsr_pkg::byte_t p_next;
    fmsr_pkg::byte_t r_reg;
    fmsr_pkg::byte_t r_next;

    always_comb
    begin
        if (ctl.w_load && (idx == ctl.w_pos))
        begin
            w_next = ctl.data;
        end
        else if (ctl.w_shift)
        begin
            w_next = w_right;
        end
        else
        begin
            w_next = w_reg;
        end

        if (ctl.p_load && (idx == ctl.p_pos))
        begin
            p_next = ctl.data;
        end
        else
        begin
            p_next = p_reg;
        end

        if (ctl.r_load && (idx == ctl.r_pos))
        begin
            r_next = ctl.data;
        end
        else if (ctl.r_rot && (idx < ctl.r_len))
        begin
            if (idx == (ctl.r_len - fmsr_pkg::cnt_t'(1)))
            begin
                r_next = r_head;
            end
            else
            begin
                r_next = r_right;
            end
        end
        else
        begin
            r_next = r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        p_reg <= p_next;
        r_reg <= r_next;
    end

    assign w_byte = w_reg;
    assign r_byte = r_reg;
    assign hit    = (w_reg == p_reg) || (idx >= ctl.p_len);

endmodule

`default_nettype wire

>>> hdl/first_match_substring_replace.sv
// Top level of the first-match substring replacement block: sequencer and output stage.
// Depends on fmsr_pkg and on a chain of fmsr_cell instances.
//
// Usage: one input channel (in_valid, in_stall) carries action, value, first and last;
// action selects a pattern byte, a replacement byte or a text byte. One output channel
// (out_valid, out_stall) carries out_byte, last_of_run and end_of_text, one byte per
// transfer. A chain of cells holds the pattern, the text window and the replacement;
// every cell compares its window byte with its pattern byte, so a full match is known
// in the cycle after a text byte enters the window.
// Sequencing: a text byte that passes straight through after the match is accepted and
// closed; a text byte that enters the window also goes through a compare step. A match
// adds a replacement burst, a flush emits the window bytes still held, and for an empty
// pattern the text byte itself follows the replacement. Replacement bytes are only
// stored; a pattern byte flushes the window and then closes. No new item is accepted
// until the sequencer is back in idle.
// Results are held back one step inside the block so that the final one can carry
// last_of_run; a stalled output simply holds the sequencer until it drains.
// Reset clears the lengths, the window fill and the match flag; no clearing pass.
`default_nettype none

module first_match_substring_replace (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  value,
    input  wire logic        first,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             end_of_text
);

    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_REPLACE = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;

    localparam fmsr_pkg::cnt_t PAT_CAP = fmsr_pkg::cnt_t'(fmsr_pkg::MAX_PAT);
    localparam fmsr_pkg::cnt_t REP_CAP = fmsr_pkg::cnt_t'(fmsr_pkg::MAX_REP);
    localparam fmsr_pkg::cnt_t ONE     = fmsr_pkg::cnt_t'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_REPL,
        S_VAL,
        S_FLUSH,
        S_END
    } state_t;

    state_t              state_reg, state_next;
    fmsr_pkg::cnt_t      plen_reg, plen_next;
    fmsr_pkg::cnt_t      rlen_reg, rlen_next;
    fmsr_pkg::cnt_t      fill_reg, fill_next;
    fmsr_pkg::cnt_t      rcnt_reg, rcnt_next;
    logic                match_done_reg, match_done_next;
    logic                val_after_reg, val_after_next;
    logic                item_text_reg, item_text_next;
    logic                item_last_reg, item_last_next;
    fmsr_pkg::byte_t     item_val_reg, item_val_next;
    logic                pend_valid_reg, pend_valid_next;
    fmsr_pkg::byte_t     pend_byte_reg, pend_byte_next;
    logic                out_valid_reg, out_valid_next;
    fmsr_pkg::byte_t     out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic                out_eot_reg, out_eot_next;

    fmsr_pkg::cell_ctl_t ctl;
    fmsr_pkg::byte_t     w_arr [fmsr_pkg::NUM_CELLS];
    fmsr_pkg::byte_t     r_arr [fmsr_pkg::NUM_CELLS];
    logic [fmsr_pkg::NUM_CELLS-1:0] hit_vec;
    logic                all_hit;

    logic                out_free;
    logic                can_emit;
    logic                emit;
    fmsr_pkg::byte_t     emit_byte;
    logic                fin;
    state_t              tail_state;

    genvar gi;
    generate
        for (gi = 0; gi < fmsr_pkg::NUM_CELLS; gi++)
        begin : g_cell
            fmsr_pkg::byte_t w_right;
            fmsr_pkg::byte_t r_right;
            if (gi < fmsr_pkg::NUM_CELLS - 1)
            begin : g_mid
                assign w_right = w_arr[gi + 1];
                assign r_right = r_arr[gi + 1];
            end
            else
            begin : g_end
                assign w_right = '0;
                assign r_right = '0;
            end
            fmsr_cell u_cell (
                .clk     (clk),
                .idx     (fmsr_pkg::cnt_t'(gi)),
                .ctl     (ctl),
                .w_right (w_right),
                .r_right (r_right),
                .r_head  (r_arr[0]),
                .w_byte  (w_arr[gi]),
                .r_byte  (r_arr[gi]),
                .hit     (hit_vec[gi])
            );
        end
    endgenerate

    assign all_hit  = &hit_vec;
    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !pend_valid_reg || out_free;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        plen_next       = plen_reg;
        rlen_next       = rlen_reg;
        fill_next       = fill_reg;
        rcnt_next       = rcnt_reg;
        match_done_next = match_done_reg;
        val_after_next  = val_after_reg;
        item_text_next  = item_text_reg;
        item_last_next  = item_last_reg;
        item_val_next   = item_val_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_eot_next    = out_eot_reg;
        emit            = 1'b0;
        emit_byte       = '0;
        fin             = 1'b0;
        tail_state      = item_last_reg ? S_FLUSH : S_END;

        ctl         = '0;
        ctl.p_len   = plen_reg;
        ctl.r_len   = rlen_reg;
        ctl.data    = value;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_val_next  = value;
                    item_last_next = last;
                    item_text_next = (action == ACT_TEXT);
                    case (action)
                        ACT_PATTERN:
                        begin
                            ctl.p_pos = first ? '0 : plen_reg;
                            if (first || (plen_reg < PAT_CAP))
                            begin
                                ctl.p_load = 1'b1;
                                plen_next  = ctl.p_pos + ONE;
                            end
                            state_next = S_FLUSH;
                        end
                        ACT_REPLACE:
                        begin
                            ctl.r_pos = first ? '0 : rlen_reg;
                            if (first || (rlen_reg < REP_CAP))
                            begin
                                ctl.r_load = 1'b1;
                                rlen_next  = ctl.r_pos + ONE;
                            end
                        end
                        ACT_TEXT:
                        begin
                            if (match_done_reg)
                            begin
                                emit       = 1'b1;
                                emit_byte  = value;
                                state_next = last ? S_FLUSH : S_END;
                            end
                            else if (plen_reg == '0)
                            begin
                                match_done_next = 1'b1;
                                rcnt_next       = '0;
                                val_after_next  = 1'b1;
                                state_next      = S_REPL;
                            end
                            else
                            begin
                                ctl.w_load = 1'b1;
                                if (fill_reg == plen_reg)
                                begin
                                    emit        = 1'b1;
                                    emit_byte   = w_arr[0];
                                    ctl.w_shift = 1'b1;
                                    ctl.w_pos   = fill_reg - ONE;
                                end
                                else
                                begin
                                    ctl.w_pos = fill_reg;
                                    fill_next = fill_reg + ONE;
                                end
                                state_next = S_CMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                if ((fill_reg == plen_reg) && all_hit)
                begin
                    fill_next       = '0;
                    match_done_next = 1'b1;
                    rcnt_next       = '0;
                    val_after_next  = 1'b0;
                    state_next      = S_REPL;
                end
                else
                begin
                    state_next = tail_state;
                end
            end
            S_REPL:
            begin
                if (rcnt_reg == rlen_reg)
                begin
                    state_next = val_after_reg ? S_VAL : tail_state;
                end
                else if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = r_arr[0];
                    ctl.r_rot = 1'b1;
                    rcnt_next = rcnt_reg + ONE;
                end
            end
            S_VAL:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_byte  = item_val_reg;
                    state_next = tail_state;
                end
            end
            S_FLUSH:
            begin
                if (fill_reg == '0)
                begin
                    if (item_text_reg)
                    begin
                        match_done_next = 1'b0;
                    end
                    state_next = S_END;
                end
                else if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_byte   = w_arr[0];
                    ctl.w_shift = 1'b1;
                    fill_next   = fill_reg - ONE;
                end
            end
            S_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
                out_eot_next   = 1'b0;
            end
        end
        if (fin)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            out_eot_next    = item_text_reg && item_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            plen_reg       <= '0;
            rlen_reg       <= '0;
            fill_reg       <= '0;
            rcnt_reg       <= '0;
            match_done_reg <= 1'b0;
            val_after_reg  <= 1'b0;
            item_text_reg  <= 1'b0;
            item_last_reg  <= 1'b0;
            item_val_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_eot_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            plen_reg       <= plen_next;
            rlen_reg       <= rlen_next;
            fill_reg       <= fill_next;
            rcnt_reg       <= rcnt_next;
            match_done_reg <= match_done_next;
            val_after_reg  <= val_after_next;
            item_text_reg  <= item_text_next;
            item_last_reg  <= item_last_next;
            item_val_reg   <= item_val_next;
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_eot_reg    <= out_eot_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign end_of_text = out_eot_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FLUSH) |-> (fill_reg <= plen_reg))
        else $error("window fill exceeds pattern length");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("result still pending while idle");

    a_match_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        match_done_reg |-> (fill_reg == '0))
        else $error("window holds bytes after a match");

    a_repl_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPL) |-> (rcnt_reg <= rlen_reg))
        else $error("replacement count overran");

endmodule

`default_nettype wire
